/* rtl/assert_macros.svh */
// assertion macros for the blend unit rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent on the same edge
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition never holds
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* rtl/tpb_pkg.sv */
// shared types and constants of the tiled pixel blend unit
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package tpb_pkg;

    // surface size clamp used when clipping
    localparam int          MAX_DIM = 4096;
    localparam logic [13:0] DIM_LIM = 14'(MAX_DIM);

    localparam int ADDR_BITS_DEF = 25;
    // widest address formed before wrapping to the port width
    localparam int FULL_ADDR_W   = 32;

    localparam int COORD_W = 14;
    localparam int DIM_W   = 13;
    localparam int PITCH_W = 14;
    localparam int CFG_W   = 14;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PITCH  = 2'd2;
    localparam logic [1:0] CFG_TILED  = 2'd3;

    // request types
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] TOP_BYTE     = 8'hFF;

    typedef struct packed {
        logic valid;
        logic inb;
        logic wr;
        logic opaque;
    } t_ctl;

    typedef struct packed {
        t_ctl             ctl;
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [31:0]      color;
        logic [7:0]       alpha;
        logic [31:0]      bg;
    } t_s1;

endpackage

/* rtl/tiled_pixel_blend_unit.sv */
// top level of the tiled pixel blend unit: config registers, control pipe
// depends on tpb_pkg, tpb_clip, tpb_addr, tpb_blend, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Pixel address and blend unit for a 32-bit framebuffer.
// Requests: a beat is taken at every rising edge with start high and busy
// low. busy never rises, so one request per clock is sustained.
// Results: exactly one per request, on the o_ ports for a single cycle while
// o_strobe is high, after passing the clip register, the multiply register
// and the divide/assemble register. The receiver cannot stall;
// it must take each result in the cycle it appears.
// Each request gives the element address (linear or 8-pipe/16-bank macro
// tiled), the in-bounds flag and, for writes, the blended data and enable.
// Out-of-bounds requests report zero address and data.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index at the
// clock edge; write only while no result is pending.
// Reset (synchronous, active low) clears the config registers and drops
// every beat in flight; no clearing pass is needed.
module tiled_pixel_blend_unit #(
    parameter int ADDR_BITS = tpb_pkg::ADDR_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_req_type,
    input  logic signed [13:0]         i_pos_x,
    input  logic signed [13:0]         i_pos_y,
    input  logic [31:0]                i_src_color,
    input  logic [7:0]                 i_src_alpha,
    input  logic [31:0]                i_background,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [tpb_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                       o_strobe,
    output logic [ADDR_BITS-1:0]       o_pixel_address,
    output logic                       o_in_bounds,
    output logic                       o_write_enable,
    output logic [31:0]                o_write_data
);
    import tpb_pkg::*;

    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [PITCH_W-1:0] r_pitch;
    logic               r_tiled;
    logic               take;
    t_s1                s1;
    t_ctl               r_ctl2;
    t_ctl               r_ctl3;
    logic [ADDR_BITS-1:0] addr;
    logic [31:0]        data;

    // fully pipelined, never holds off a request
    assign busy = 1'b0;
    assign take = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
            r_pitch  <= '0;
            r_tiled  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                CFG_PITCH:  r_pitch  <= i_cfg_data[PITCH_W-1:0];
                CFG_TILED:  r_tiled  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tpb_clip u_clip (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_req_type  (i_req_type),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_src_color (i_src_color),
        .i_src_alpha (i_src_alpha),
        .i_background(i_background),
        .i_width     (r_width),
        .i_height    (r_height),
        .o_s1        (s1)
    );

    tpb_addr #(
        .ADDR_BITS(ADDR_BITS)
    ) u_addr (
        .i_clk  (i_clk),
        .i_x    (s1.x),
        .i_y    (s1.y),
        .i_pitch(r_pitch),
        .i_tiled(r_tiled),
        .o_addr (addr)
    );

    tpb_blend u_blend (
        .i_clk   (i_clk),
        .i_color (s1.color),
        .i_bg    (s1.bg),
        .i_alpha (s1.alpha),
        .i_opaque(s1.ctl.opaque),
        .o_data  (data)
    );

    // control travels alongside the payload stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else begin
            r_ctl2 <= s1.ctl;
            r_ctl3 <= r_ctl2;
        end
    end

    assign o_strobe        = r_ctl3.valid;
    assign o_in_bounds     = r_ctl3.valid && r_ctl3.inb;
    assign o_write_enable  = r_ctl3.valid && r_ctl3.wr;
    assign o_pixel_address = o_in_bounds ? addr : '0;
    assign o_write_data    = o_write_enable ? data : 32'd0;

    `ASSERT_IMP(a_lat3, i_clk, i_rst_n, take, ##3 o_strobe, "result missing three cycles after request")
    `ASSERT_IMP(a_no_spur, i_clk, i_rst_n, o_strobe, $past(take, 3), "result without a request")
    `ASSERT_NEVER(a_we_inb, i_clk, i_rst_n, o_write_enable && !o_in_bounds, "write outside surface")
    `ASSERT_IMP(a_wd_zero, i_clk, i_rst_n, !o_write_enable, o_write_data == 32'd0, "stray write data")

endmodule

/* rtl/tpb_clip.sv */
// input stage: clips the request against the surface and registers the beat
// depends on tpb_pkg
`timescale 1ns / 1ps

module tpb_clip (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic                       i_req_type,
    input  logic signed [13:0]         i_pos_x,
    input  logic signed [13:0]         i_pos_y,
    input  logic [31:0]                i_src_color,
    input  logic [7:0]                 i_src_alpha,
    input  logic [31:0]                i_background,
    input  logic [tpb_pkg::DIM_W-1:0]  i_width,
    input  logic [tpb_pkg::DIM_W-1:0]  i_height,
    output tpb_pkg::t_s1               o_s1
);
    import tpb_pkg::*;

    logic [13:0] w_lim;
    logic [13:0] h_lim;
    logic        x_ok;
    logic        y_ok;
    logic        inb;
    t_s1         n_s1;
    t_s1         r_s1;

    always_comb begin
        w_lim = ({1'b0, i_width} > DIM_LIM) ? DIM_LIM : {1'b0, i_width};
        h_lim = ({1'b0, i_height} > DIM_LIM) ? DIM_LIM : {1'b0, i_height};
        // sign bit clear and below the clamped size
        x_ok  = !i_pos_x[13] && ({1'b0, i_pos_x[12:0]} < w_lim);
        y_ok  = !i_pos_y[13] && ({1'b0, i_pos_y[12:0]} < h_lim);
        inb   = x_ok && y_ok;

        n_s1.ctl.valid  = i_take;
        n_s1.ctl.inb    = inb;
        n_s1.ctl.wr     = inb && (i_req_type == REQ_WRITE) && (i_src_alpha != 8'd0);
        n_s1.ctl.opaque = (i_src_alpha == ALPHA_OPAQUE);
        n_s1.x          = i_pos_x[12:0];
        n_s1.y          = i_pos_y[12:0];
        n_s1.color      = i_src_color;
        n_s1.alpha      = i_src_alpha;
        n_s1.bg         = i_background;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.ctl <= '0;
        end else begin
            r_s1.ctl <= n_s1.ctl;
        end
        r_s1.x     <= n_s1.x;
        r_s1.y     <= n_s1.y;
        r_s1.color <= n_s1.color;
        r_s1.alpha <= n_s1.alpha;
        r_s1.bg    <= n_s1.bg;
    end

    assign o_s1 = r_s1;

endmodule

/* rtl/tpb_addr.sv */
// address stages: multiply stage then linear or macro-tiled address assembly
// depends on tpb_pkg
`timescale 1ns / 1ps

module tpb_addr #(
    parameter int ADDR_BITS = tpb_pkg::ADDR_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic [tpb_pkg::DIM_W-1:0]    i_x,
    input  logic [tpb_pkg::DIM_W-1:0]    i_y,
    input  logic [tpb_pkg::PITCH_W-1:0]  i_pitch,
    input  logic                         i_tiled,
    output logic [ADDR_BITS-1:0]         o_addr
);
    import tpb_pkg::*;

    localparam int LIN_W  = DIM_W + PITCH_W;
    localparam int TILE_W = 14;

    logic [LIN_W-1:0]     r_lin_prod;
    logic [TILE_W-1:0]    r_tile_prod;
    logic [DIM_W-1:0]     r_x;
    logic [6:0]           r_ylo;
    logic [LIN_W:0]       lin_addr;
    logic [TILE_W-1:0]    tile_idx;
    logic [5:0]           pix;
    logic [2:0]           pipe;
    logic [3:0]           bank;
    logic [TILE_W+12:0]   tile_addr;
    logic [FULL_ADDR_W-1:0] full_addr;
    logic [ADDR_BITS-1:0] n_addr;
    logic [ADDR_BITS-1:0] r_addr;

    // stage 2: row times pitch, macro-tile row times tiles per row
    always_ff @(posedge i_clk) begin
        r_lin_prod  <= LIN_W'(i_y) * LIN_W'(i_pitch);
        r_tile_prod <= TILE_W'(i_y[12:6]) * TILE_W'(i_pitch[13:7]);
        r_x         <= i_x;
        r_ylo       <= i_y[6:0];
    end

    always_comb begin
        lin_addr = (LIN_W + 1)'(r_lin_prod) + (LIN_W + 1)'(r_x);
        tile_idx = r_tile_prod + TILE_W'(r_x[12:7]);
        pix  = {r_ylo[2], r_ylo[1], r_x[2], r_ylo[0], r_x[1], r_x[0]};
        pipe = {r_x[5] ^ r_ylo[5],
                r_x[4] ^ r_ylo[4],
                r_x[3] ^ r_ylo[3] ^ r_x[4]};
        bank = {r_x[9] ^ r_ylo[3],
                r_x[8] ^ r_ylo[4],
                r_x[7] ^ r_ylo[5] ^ r_ylo[6],
                r_x[6] ^ r_ylo[6]};
        tile_addr = {tile_idx, bank, pipe, pix};
        full_addr = i_tiled ? FULL_ADDR_W'(tile_addr) : FULL_ADDR_W'(lin_addr);
        // wraps to the port width
        n_addr    = full_addr[ADDR_BITS-1:0];
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
    end

    assign o_addr = r_addr;

endmodule

/* rtl/tpb_blend.sv */
// blend stages: per-channel products then divide by 255 and opaque select
// depends on tpb_pkg
`timescale 1ns / 1ps

module tpb_blend (
    input  logic        i_clk,
    input  logic [31:0] i_color,
    input  logic [31:0] i_bg,
    input  logic [7:0]  i_alpha,
    input  logic        i_opaque,
    output logic [31:0] o_data
);
    import tpb_pkg::*;

    logic [15:0] n_sum [3];
    logic [15:0] r_sum [3];
    logic [31:0] r_color;
    logic        r_opaque;
    logic [16:0] q_acc [3];
    logic [31:0] n_data;
    logic [31:0] r_data;

    always_comb begin
        // background weight is 255 - alpha, formed at 8 bits before widening
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = 16'(i_color[8*c +: 8]) * 16'(i_alpha)
                     + 16'(i_bg[8*c +: 8]) * 16'(8'(ALPHA_OPAQUE - i_alpha));
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_color  <= i_color;
        r_opaque <= i_opaque;
    end

    always_comb begin
        // exact n / 255 for the sums here (n <= 255 * 255): (n + 1 + (n >> 8)) >> 8
        for (int c = 0; c < 3; c++) begin
            q_acc[c] = {1'b0, r_sum[c]} + 17'd1 + 17'(r_sum[c][15:8]);
        end
        n_data = r_opaque ? r_color
                          : {TOP_BYTE, q_acc[2][15:8], q_acc[1][15:8], q_acc[0][15:8]};
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* tb/tb.sv */
// testbench of tiled_pixel_blend_unit: clip, linear and macro-tiled addressing, alpha blend
// depends on tpb_pkg and the rtl of the block; self-checking against its own pixel predictor
`timescale 1ns / 1ps

module tb;
    import tpb_pkg::*;

    localparam int ADDR_W   = ADDR_BITS_DEF;
    localparam int WATCHDOG = 3000;

    typedef struct {
        logic               req;
        logic signed [13:0] x;
        logic signed [13:0] y;
        logic [31:0]        color;
        logic [7:0]         alpha;
        logic [31:0]        bg;
    } t_pixel_req;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic              inb;
        logic              we;
        logic [31:0]       data;
    } t_pixel_res;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic               start        = 1'b0;
    logic               busy;
    logic               i_req_type   = 1'b0;
    logic signed [13:0] i_pos_x      = '0;
    logic signed [13:0] i_pos_y      = '0;
    logic [31:0]        i_src_color  = '0;
    logic [7:0]         i_src_alpha  = '0;
    logic [31:0]        i_background = '0;
    logic               i_cfg_we     = 1'b0;
    logic [1:0]         i_cfg_index  = CFG_WIDTH;
    logic [CFG_W-1:0]   i_cfg_data   = '0;

    logic              o_strobe;
    logic [ADDR_W-1:0] o_pixel_address;
    logic              o_in_bounds;
    logic              o_write_enable;
    logic [31:0]       o_write_data;

    // mirror of the configuration registers
    logic [12:0] surf_w     = '0;
    logic [12:0] surf_h     = '0;
    logic [13:0] surf_pitch = '0;
    logic        surf_tiled = 1'b0;

    t_pixel_req pending_reqs[$];
    t_pixel_res expected_pixels[$];
    t_pixel_req drive_req;
    int         idle_pct    = 0;
    int         mismatches  = 0;
    int         idle_cycles = 0;

    tiled_pixel_blend_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_src_color     (i_src_color),
        .i_src_alpha     (i_src_alpha),
        .i_background    (i_background),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_pixel_address (o_pixel_address),
        .o_in_bounds     (o_in_bounds),
        .o_write_enable  (o_write_enable),
        .o_write_data    (o_write_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic t_pixel_res predict_pixel(t_pixel_req rq);
        t_pixel_res  res;
        int          xi, yi, wl, hl;
        logic [12:0] ux, uy;
        logic [5:0]  micro;
        logic [2:0]  pipe;
        logic [3:0]  bank;
        logic [63:0] tile, full;
        int unsigned mix;
        res.addr = '0;
        res.inb  = 1'b0;
        res.we   = 1'b0;
        res.data = '0;
        xi = rq.x;
        yi = rq.y;
        wl = (int'(surf_w) > MAX_DIM) ? MAX_DIM : int'(surf_w);
        hl = (int'(surf_h) > MAX_DIM) ? MAX_DIM : int'(surf_h);
        if (xi >= 0 && yi >= 0 && xi < wl && yi < hl) begin
            ux = 13'(xi);
            uy = 13'(yi);
            res.inb = 1'b1;
            if (surf_tiled) begin
                micro = {uy[2], uy[1], ux[2], uy[0], ux[1], ux[0]};
                pipe  = {ux[5] ^ uy[5], ux[4] ^ uy[4], ux[3] ^ uy[3] ^ ux[4]};
                bank  = {ux[9] ^ uy[3], ux[8] ^ uy[4], ux[7] ^ uy[5] ^ uy[6], ux[6] ^ uy[6]};
                // macro-tile rows are whole multiples of 128 pixels of pitch
                tile  = 64'(uy >> 6) * 64'(surf_pitch >> 7) + 64'(ux >> 7);
                full  = (tile << 13) | (64'(bank) << 9) | (64'(pipe) << 6) | 64'(micro);
            end else begin
                full = 64'(uy) * 64'(surf_pitch) + 64'(ux);
            end
            res.addr = full[ADDR_W-1:0];
            if (rq.req == REQ_WRITE && rq.alpha != 8'd0) begin
                res.we = 1'b1;
                if (rq.alpha == ALPHA_OPAQUE) begin
                    res.data = rq.color;
                end else begin
                    res.data = {TOP_BYTE, 24'h0};
                    for (int ch = 0; ch < 3; ch++) begin
                        mix = (int'(rq.color[8*ch +: 8]) * int'(rq.alpha)
                             + int'(rq.bg[8*ch +: 8]) * (255 - int'(rq.alpha))) / 255;
                        res.data[8*ch +: 8] = mix[7:0];
                    end
                end
            end
        end
        return res;
    endfunction

    // mostly inside the surface, some on the clip edges, some anywhere
    function automatic logic signed [13:0] pick_coord(logic [12:0] dim);
        int lim;
        int sel;
        lim = (int'(dim) > MAX_DIM) ? MAX_DIM : int'(dim);
        sel = $urandom_range(0, 99);
        if (sel < 70 && lim > 0)
            return 14'($urandom_range(0, lim - 1));
        if (sel < 88) begin
            case ($urandom_range(0, 5))
                0: return 14'(lim - 1);
                1: return 14'(lim);
                2: return -14'sd1;
                3: return 14'sd0;
                4: return 14'sh1FFF;
                default: return 14'sh2000;
            endcase
        end
        return 14'($urandom);
    endfunction

    function automatic t_pixel_req random_px();
        t_pixel_req rq;
        int         sel;
        rq.req   = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
        rq.x     = pick_coord(surf_w);
        rq.y     = pick_coord(surf_h);
        rq.color = $urandom;
        rq.bg    = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            rq.alpha = 8'd0;
        else if (sel < 30)
            rq.alpha = ALPHA_OPAQUE;
        else if (sel < 40)
            rq.alpha = $urandom_range(0, 1) ? 8'd1 : 8'd254;
        else
            rq.alpha = 8'($urandom);
        return rq;
    endfunction

    task automatic queue_px(logic req, logic signed [13:0] x, logic signed [13:0] y,
                            logic [31:0] color, logic [7:0] alpha, logic [31:0] bg);
        t_pixel_req rq;
        rq.req   = req;
        rq.x     = x;
        rq.y     = y;
        rq.color = color;
        rq.alpha = alpha;
        rq.bg    = bg;
        pending_reqs.push_back(rq);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_WIDTH:  surf_w     = value[12:0];
            CFG_HEIGHT: surf_h     = value[12:0];
            CFG_PITCH:  surf_pitch = value;
            default:    surf_tiled = value[0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_surface(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                               logic [CFG_W-1:0] pitch, logic [CFG_W-1:0] tiled);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_PITCH, pitch);
        write_reg(CFG_TILED, tiled);
    endtask

    // wait for every queued beat to be taken and every result to come back
    task automatic wait_idle();
        while (pending_reqs.size() > 0 || start || expected_pixels.size() > 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                             logic [CFG_W-1:0] pitch, logic [CFG_W-1:0] tiled,
                             int n, int idle);
        set_surface(w, h, pitch, tiled);
        idle_pct = idle;
        repeat (n) pending_reqs.push_back(random_px());
        wait_idle();
    endtask

    // driver: one beat per accepting edge, random gaps per idle_pct
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                expected_pixels.push_back(predict_pixel(drive_req));
            if (!start || !busy) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    drive_req = pending_reqs.pop_front();
                    start        <= 1'b1;
                    i_req_type   <= drive_req.req;
                    i_pos_x      <= drive_req.x;
                    i_pos_y      <= drive_req.y;
                    i_src_color  <= drive_req.color;
                    i_src_alpha  <= drive_req.alpha;
                    i_background <= drive_req.bg;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_pixel_res exp_px;
        if (i_rst_n && o_strobe) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result beat, address %h", o_pixel_address);
                mismatches++;
            end else begin
                exp_px = expected_pixels.pop_front();
                if (o_pixel_address !== exp_px.addr) begin
                    $error("pixel_address: expected %h, got %h", exp_px.addr, o_pixel_address);
                    mismatches++;
                end
                if (o_in_bounds !== exp_px.inb) begin
                    $error("in_bounds: expected %b, got %b", exp_px.inb, o_in_bounds);
                    mismatches++;
                end
                if (o_write_enable !== exp_px.we) begin
                    $error("write_enable: expected %b, got %b", exp_px.we, o_write_enable);
                    mismatches++;
                end
                if (o_write_data !== exp_px.data) begin
                    $error("write_data: expected %h, got %h", exp_px.data, o_write_data);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // linear clipping, blend corners
        set_surface(14'd100, 14'd50, 14'd128, 14'd0);
        idle_pct = 0;
        queue_px(REQ_READ, 14'sd0, 14'sd0, 32'h0, 8'd0, 32'h0);
        queue_px(REQ_READ, 14'sd99, 14'sd49, 32'h0, 8'd0, 32'h0);
        queue_px(REQ_READ, 14'sd100, 14'sd0, 32'h0, 8'd0, 32'h0);
        queue_px(REQ_READ, 14'sd0, 14'sd50, 32'h0, 8'd0, 32'h0);
        queue_px(REQ_READ, -14'sd1, 14'sd0, 32'h0, 8'd0, 32'h0);
        queue_px(REQ_READ, 14'sd0, -14'sd1, 32'h0, 8'd0, 32'h0);
        queue_px(REQ_READ, 14'sh2000, 14'sh1FFF, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF);
        queue_px(REQ_READ, 14'sh1FFF, 14'sh2000, 32'h0, 8'd0, 32'h0);
        queue_px(REQ_WRITE, 14'sd5, 14'sd7, 32'hA5A5A5A5, ALPHA_OPAQUE, 32'h5A5A5A5A);
        queue_px(REQ_WRITE, 14'sd5, 14'sd7, 32'hA5A5A5A5, 8'd0, 32'h5A5A5A5A);
        queue_px(REQ_WRITE, 14'sd6, 14'sd8, 32'hFFFFFFFF, 8'd1, 32'h00000000);
        queue_px(REQ_WRITE, 14'sd7, 14'sd9, 32'h00000000, 8'd254, 32'hFFFFFFFF);
        queue_px(REQ_WRITE, 14'sd8, 14'sd10, 32'h12C4F0A0, 8'd128, 32'h7E3B0FFF);
        queue_px(REQ_WRITE, 14'sd100, 14'sd49, 32'h11223344, ALPHA_OPAQUE, 32'h0);
        queue_px(REQ_WRITE, -14'sd1, -14'sd1, 32'h11223344, 8'd128, 32'h55667788);
        queue_px(REQ_WRITE, 14'sd99, 14'sd0, 32'h00000000, ALPHA_OPAQUE, 32'hFFFFFFFF);
        wait_idle();

        // tiled, oversized width saturates, pitch wraps the address
        set_surface(14'h3FFF, 14'd4096, 14'h3FFF, 14'h3FFF);
        queue_px(REQ_READ, 14'sd4095, 14'sd4095, 32'h0, 8'd0, 32'h0);
        queue_px(REQ_READ, 14'sd4096, 14'sd0, 32'h0, 8'd0, 32'h0);
        queue_px(REQ_READ, 14'sd0, 14'sd4096, 32'h0, 8'd0, 32'h0);
        queue_px(REQ_WRITE, 14'sd4095, 14'sd4095, 32'hDEADBEEF, 8'd200, 32'h01020304);
        queue_px(REQ_READ, 14'sh2AA, 14'sh155, 32'h0, 8'd0, 32'h0);
        queue_px(REQ_READ, 14'sh155, 14'sh2AA, 32'h0, 8'd0, 32'h0);
        queue_px(REQ_WRITE, 14'sd127, 14'sd63, 32'hCAFEF00D, ALPHA_OPAQUE, 32'h0);
        queue_px(REQ_WRITE, 14'sd128, 14'sd64, 32'hCAFEF00D, 8'd0, 32'h0);
        wait_idle();

        run_phase(14'd640, 14'd480, 14'd640, 14'd0, 80, 0);
        run_phase(14'd4096, 14'd4096, 14'd4096, 14'd1, 80, 88);
        run_phase(14'h3FFF, 14'd4096, 14'h3FFF, 14'h3FFE, 80, 6);
        run_phase(14'd1000, 14'd700, 14'd300, 14'd1, 70, 0);
        run_phase(14'd4096, 14'd4096, 14'h3FFF, 14'd1, 60, 88);
        run_phase(14'd0, 14'd0, 14'd0, 14'd0, 30, 6);
        run_phase(14'd1, 14'd1, 14'd128, 14'd1, 30, 0);
        run_phase(14'd4096, 14'd1, 14'd8192, 14'd0, 50, 88);
        run_phase(14'd200, 14'd4096, 14'd8192, 14'd1, 50, 6);

        repeat (8) @(posedge i_clk);
        if (expected_pixels.size() > 0) begin
            $error("%0d result beats never arrived", expected_pixels.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/tpb_pkg.sv
rtl/tpb_clip.sv
rtl/tpb_addr.sv
rtl/tpb_blend.sv
rtl/tiled_pixel_blend_unit.sv
tb/tb.sv
